// ===== hdl/pls_pkg.sv =====
// Shared types and codes for the priority load shedder.
package pls_pkg;

   localparam int ENTRY_PRIO_W = 3;
   localparam int ENTRY_CUR_W  = 16;
   localparam int ENTRY_POW_W  = 20;
   localparam int GEN_CUR_W    = 20;
   localparam int SPARE_PWR_W  = 21;
   localparam int DEMAND_OUT_W = 20;
   localparam int COUNT_W      = 5;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_LEVEL = 2'd1;
   localparam logic [1:0] OP_REACT = 2'd2;
   localparam logic [1:0] OP_DEPL  = 2'd3;

   localparam logic [1:0] LEVEL_WARN  = 2'd1;
   localparam logic [1:0] LEVEL_OTHER = 2'd2;

   localparam logic [1:0] ACT_NONE  = 2'd0;
   localparam logic [1:0] ACT_SHED  = 2'd1;
   localparam logic [1:0] ACT_REACT = 2'd2;
   localparam logic [1:0] ACT_LOAD  = 2'd3;

   localparam logic [2:0] GROUP_FIRST   = 3'd1;
   localparam logic [2:0] GROUP_LOWSHED = 3'd2;
   localparam logic [2:0] GROUP_MID     = 3'd3;
   localparam logic [2:0] GROUP_LAST    = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      MD_SHED,
      MD_REACT,
      MD_SUM,
      MD_CUT,
      MD_ALL
   } mode_type;

   typedef struct packed {
      logic [ENTRY_PRIO_W-1:0] prio;
      logic [ENTRY_CUR_W-1:0]  cur;
      logic [ENTRY_POW_W-1:0]  pow;
   } entry_type;

   typedef struct packed {
      logic we;
      logic value;
   } mark_cmd_type;

endpackage

// ===== hdl/priority_load_shedder.sv =====
// Load item: one word in the cycle after accept; busy stays low, so loads can come every cycle.
// Other items scan one entry per cycle on the single memory read port and hold busy until
// done (level tick, reactivate or depletion; the scan covers the n entries in use); the
// final word is out, and the next item can be taken, in the first cycle with busy low.
// Words come at most one per cycle on a strobe; the receiver cannot stall them.
// Synchronous active-high reset clears the marks, the count and the sequencer, not the entries.
module priority_load_shedder
   import pls_pkg::*;
#(
   parameter int MAX_CONSUMERS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_op,
   input  logic [3:0]              req_entry_index,
   input  logic [ENTRY_PRIO_W-1:0] req_entry_priority,
   input  logic [ENTRY_CUR_W-1:0]  req_entry_current,
   input  logic [ENTRY_POW_W-1:0]  req_entry_power,
   input  logic                    req_entry_active,
   input  logic [1:0]              req_power_level,
   input  logic                    req_generator_present,
   input  logic [GEN_CUR_W-1:0]    req_generator_current,
   input  logic signed [SPARE_PWR_W-1:0] req_headroom_power,
   input  logic                    csr_wr_en,
   input  logic [COUNT_W-1:0]      csr_wr_data,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_action,
   output logic [3:0]              rsp_consumer_index,
   output logic [DEMAND_OUT_W-1:0] rsp_remaining_demand,
   output logic                    rsp_last
);

   localparam int IDX_W = (MAX_CONSUMERS > 1) ? $clog2(MAX_CONSUMERS) : 1;
   localparam int CNT_W = $clog2(MAX_CONSUMERS + 1);
   localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam int SUM_W = ENTRY_CUR_W + CNT_W;
   localparam int DEM_W = (SUM_W > GEN_CUR_W + 1) ? SUM_W : GEN_CUR_W + 1;

   state_type                state_ff, state_in;
   mode_type                 mode_ff, mode_in;
   logic [COUNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]         n_ff, n_in, n_now;
   logic [IDX_W-1:0]         last_idx;
   logic [2:0]               group_ff, group_in;
   logic [IDX_W-1:0]         ptr_ff, ptr_in;
   logic                     issue_ff, issue_in;
   logic                     ev_valid_ff, ev_valid_in;
   logic [IDX_W-1:0]         ev_addr_ff, ev_addr_in;
   logic [2:0]               ev_group_ff, ev_group_in;
   logic [DEM_W-1:0]         demand_ff, demand_in;
   logic                     gen_ff, gen_in;
   logic [GEN_CUR_W-1:0]     avail_ff, avail_in;
   logic [ENTRY_POW_W-1:0]   headroom_ff, headroom_in;

   logic                     pend_valid_ff, pend_valid_in;
   logic [1:0]               pend_action_ff, pend_action_in;
   logic [3:0]               pend_index_ff, pend_index_in;
   logic [DEMAND_OUT_W-1:0]  pend_demand_ff, pend_demand_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [1:0]               rsp_action_ff, rsp_action_in;
   logic [3:0]               rsp_index_ff, rsp_index_in;
   logic [DEMAND_OUT_W-1:0]  rsp_demand_ff, rsp_demand_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                     tbl_wr_en;
   entry_type                tbl_wr_data;
   entry_type                rd_data;
   mark_cmd_type             mark_cmd;
   logic [IDX_W-1:0]         mark_addr;
   logic                     mark_rd;

   logic                     accept;
   logic                     in_range;
   logic [CMP_W-1:0]         count_x;
   logic                     prio_hit;
   logic [DEM_W-1:0]         dem_sub;
   logic [DEM_W-1:0]         avail_x;
   logic                     res_v;
   logic [1:0]               res_action;
   logic [DEMAND_OUT_W-1:0]  res_demand;
   logic                     stop;
   logic                     desc;

   pls_table #(
      .MAX_CONSUMERS(MAX_CONSUMERS),
      .IDX_W(IDX_W)
   ) u_table (
      .clock(clock),
      .reset(reset),
      .wr_en(tbl_wr_en),
      .wr_addr(IDX_W'(req_entry_index)),
      .wr_data(tbl_wr_data),
      .rd_addr(ptr_ff),
      .rd_data(rd_data),
      .mark_cmd(mark_cmd),
      .mark_addr(mark_addr),
      .mark_rd_addr(ev_addr_ff),
      .mark_rd(mark_rd)
   );

   assign accept   = start && (state_ff == ST_IDLE);
   assign in_range = ({28'd0, req_entry_index} < 32'(MAX_CONSUMERS));
   assign count_x  = CMP_W'(count_ff);
   assign n_now    = (count_x > CMP_W'(MAX_CONSUMERS)) ? CNT_W'(MAX_CONSUMERS)
                                                       : CNT_W'(count_x);
   assign last_idx = IDX_W'(n_ff - CNT_W'(1));
   assign avail_x  = DEM_W'(avail_ff);
   assign dem_sub  = demand_ff - DEM_W'(rd_data.cur);
   assign prio_hit = (rd_data.prio == ev_group_ff);
   assign desc     = (mode_ff == MD_SHED) || (mode_ff == MD_CUT);

   assign tbl_wr_en             = accept && (req_op == OP_LOAD) && in_range;
   assign tbl_wr_data.prio      = req_entry_priority;
   assign tbl_wr_data.cur       = req_entry_current;
   assign tbl_wr_data.pow       = req_entry_power;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         issue_ff      <= 1'b0;
         ev_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         issue_ff      <= issue_in;
         ev_valid_ff   <= ev_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      n_ff           <= n_in;
      group_ff       <= group_in;
      ptr_ff         <= ptr_in;
      ev_addr_ff     <= ev_addr_in;
      ev_group_ff    <= ev_group_in;
      demand_ff      <= demand_in;
      gen_ff         <= gen_in;
      avail_ff       <= avail_in;
      headroom_ff    <= headroom_in;
      pend_action_ff <= pend_action_in;
      pend_index_ff  <= pend_index_in;
      pend_demand_ff <= pend_demand_in;
      rsp_action_ff  <= rsp_action_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_demand_ff  <= rsp_demand_in;
      rsp_last_ff    <= rsp_last_in;
   end

   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      n_in           = n_ff;
      group_in       = group_ff;
      ptr_in         = ptr_ff;
      issue_in       = issue_ff;
      ev_valid_in    = 1'b0;
      ev_addr_in     = ptr_ff;
      ev_group_in    = group_ff;
      demand_in      = demand_ff;
      gen_in         = gen_ff;
      avail_in       = avail_ff;
      headroom_in    = headroom_ff;
      pend_valid_in  = pend_valid_ff;
      pend_action_in = pend_action_ff;
      pend_index_in  = pend_index_ff;
      pend_demand_in = pend_demand_ff;
      rsp_valid_in   = 1'b0;
      rsp_action_in  = rsp_action_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_demand_in  = rsp_demand_ff;
      rsp_last_in    = rsp_last_ff;
      mark_cmd.we    = 1'b0;
      mark_cmd.value = 1'b0;
      mark_addr      = ev_addr_ff;
      res_v          = 1'b0;
      res_action     = ACT_SHED;
      res_demand     = '0;
      stop           = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               n_in          = n_now;
               demand_in     = '0;
               pend_valid_in = 1'b0;
               gen_in        = req_generator_present;
               avail_in      = req_generator_current;
               headroom_in   = req_headroom_power[ENTRY_POW_W-1:0];
               issue_in      = 1'b1;
               unique case (req_op)
                  OP_LOAD: begin
                     issue_in       = 1'b0;
                     mark_cmd.we    = in_range;
                     mark_cmd.value = req_entry_active;
                     mark_addr      = IDX_W'(req_entry_index);
                     rsp_valid_in   = 1'b1;
                     rsp_action_in  = in_range ? ACT_LOAD : ACT_NONE;
                     rsp_index_in   = in_range ? req_entry_index : 4'd0;
                     rsp_demand_in  = '0;
                     rsp_last_in    = 1'b1;
                  end
                  OP_LEVEL: begin
                     mode_in  = MD_SHED;
                     group_in = (req_power_level == LEVEL_WARN) ? GROUP_LAST : GROUP_MID;
                     ptr_in   = IDX_W'(n_now - CNT_W'(1));
                     if ((n_now == '0) || ((req_power_level != LEVEL_WARN) &&
                                           (req_power_level != LEVEL_OTHER))) begin
                        issue_in = 1'b0;
                        state_in = ST_FINISH;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  OP_REACT: begin
                     mode_in  = MD_REACT;
                     group_in = GROUP_FIRST;
                     ptr_in   = '0;
                     if ((n_now == '0) || req_headroom_power[SPARE_PWR_W-1]) begin
                        issue_in = 1'b0;
                        state_in = ST_FINISH;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                     mode_in = MD_SUM;
                     ptr_in  = '0;
                     if (n_now == '0) begin
                        issue_in = 1'b0;
                        state_in = ST_FINISH;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // evaluate the entry read last cycle
            if (ev_valid_ff) begin
               case (mode_ff)
                  MD_SHED: begin
                     if (mark_rd && prio_hit) begin
                        mark_cmd.we = 1'b1;
                        res_v       = 1'b1;
                        stop        = 1'b1;
                     end
                  end
                  MD_REACT: begin
                     if (!mark_rd && prio_hit && (rd_data.pow <= headroom_ff)) begin
                        mark_cmd.we    = 1'b1;
                        mark_cmd.value = 1'b1;
                        res_v          = 1'b1;
                        res_action     = ACT_REACT;
                        stop           = 1'b1;
                     end
                  end
                  MD_SUM: begin
                     if (mark_rd) begin
                        demand_in = demand_ff + DEM_W'(rd_data.cur);
                     end
                  end
                  MD_CUT: begin
                     if (mark_rd && prio_hit) begin
                        mark_cmd.we = 1'b1;
                        res_v       = 1'b1;
                        res_demand  = DEMAND_OUT_W'(dem_sub);
                        demand_in   = dem_sub;
                        stop        = (dem_sub <= avail_x);
                     end
                  end
                  default: begin
                     if (mark_rd) begin
                        mark_cmd.we = 1'b1;
                        res_v       = 1'b1;
                        res_demand  = DEMAND_OUT_W'(dem_sub);
                        demand_in   = dem_sub;
                     end
                  end
               endcase
            end

            // hold each result until the next one shows whether it is the final word
            if (res_v) begin
               if (pend_valid_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_action_in = pend_action_ff;
                  rsp_index_in  = pend_index_ff;
                  rsp_demand_in = pend_demand_ff;
                  rsp_last_in   = 1'b0;
               end
               pend_valid_in  = 1'b1;
               pend_action_in = res_action;
               pend_index_in  = 4'(ev_addr_ff);
               pend_demand_in = res_demand;
            end

            if (stop) begin
               issue_in = 1'b0;
               state_in = ST_FINISH;
            end else if (issue_ff) begin
               ev_valid_in = 1'b1;
               if (desc) begin
                  if (ptr_ff == '0) begin
                     if (group_ff == GROUP_LOWSHED) begin
                        issue_in = 1'b0;
                     end else begin
                        group_in = group_ff - 3'd1;
                        ptr_in   = last_idx;
                     end
                  end else begin
                     ptr_in = ptr_ff - IDX_W'(1);
                  end
               end else begin
                  if (ptr_ff == last_idx) begin
                     if ((mode_ff == MD_REACT) && (group_ff != GROUP_LAST)) begin
                        group_in = group_ff + 3'd1;
                        ptr_in   = '0;
                     end else begin
                        issue_in = 1'b0;
                     end
                  end else begin
                     ptr_in = ptr_ff + IDX_W'(1);
                  end
               end
            end else if (!ev_valid_ff) begin
               // pass drained: after the sum, pick the shedding pass
               if ((mode_ff == MD_SUM) && gen_ff && (demand_ff > avail_x)) begin
                  mode_in  = MD_CUT;
                  group_in = GROUP_LAST;
                  ptr_in   = last_idx;
                  issue_in = 1'b1;
               end else if ((mode_ff == MD_SUM) && !gen_ff) begin
                  mode_in  = MD_ALL;
                  ptr_in   = '0;
                  issue_in = 1'b1;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end

         ST_FINISH: begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = 1'b1;
            if (pend_valid_ff) begin
               rsp_action_in = pend_action_ff;
               rsp_index_in  = pend_index_ff;
               rsp_demand_in = pend_demand_ff;
            end else begin
               rsp_action_in = ACT_NONE;
               rsp_index_in  = 4'd0;
               rsp_demand_in = DEMAND_OUT_W'(demand_ff);
            end
            pend_valid_in = 1'b0;
            state_in      = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy                 = (state_ff != ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_action           = rsp_action_ff;
   assign rsp_consumer_index   = rsp_index_ff;
   assign rsp_remaining_demand = rsp_demand_ff;
   assign rsp_last             = rsp_last_ff;

endmodule

// ===== hdl/pls_table.sv =====
// Consumer table: entry memory with registered read, and active marks in flops.
module pls_table
   import pls_pkg::*;
#(
   parameter int MAX_CONSUMERS = 16,
   parameter int IDX_W = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  entry_type        wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_data,
   input  mark_cmd_type     mark_cmd,
   input  logic [IDX_W-1:0] mark_addr,
   input  logic [IDX_W-1:0] mark_rd_addr,
   output logic             mark_rd
);

   entry_type                mem [MAX_CONSUMERS];
   entry_type                rd_data_ff;
   logic [MAX_CONSUMERS-1:0] marks_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         marks_ff <= '0;
      end else if (mark_cmd.we) begin
         marks_ff[mark_addr] <= mark_cmd.value;
      end
   end

   assign rd_data = rd_data_ff;
   assign mark_rd = marks_ff[mark_rd_addr];

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the priority load shedder: random commands, scoreboard.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pls_pkg::*;

   localparam int ENTRIES     = 16;
   localparam int SETTLE      = 4;
   localparam int TAIL        = 80;
   localparam int CYCLE_LIMIT = 500000;
   localparam int PHASE_ITEMS = 40;
   localparam int PHASES      = 10;

   localparam logic [1:0] LEVEL_NORMAL   = 2'd0;
   localparam logic [1:0] LEVEL_DEPLETED = 2'd3;

   localparam logic [ENTRY_PRIO_W-1:0] FIRST_PRIO [ENTRIES] =
      '{3'd1, 3'd2, 3'd3, 3'd4, 3'd4, 3'd0, 3'd3, 3'd2,
        3'd4, 3'd1, 3'd7, 3'd3, 3'd5, 3'd6, 3'd2, 3'd4};

   typedef enum logic {K_ITEM, K_COUNT} cmd_kind_type;

   typedef struct {
      cmd_kind_type            kind;
      logic [1:0]              op;
      logic [3:0]              idx;
      logic [ENTRY_PRIO_W-1:0] prio;
      logic [ENTRY_CUR_W-1:0]  cur;
      logic [ENTRY_POW_W-1:0]  pow;
      logic                    act;
      logic [1:0]              level;
      logic                    gen;
      logic [GEN_CUR_W-1:0]    gen_cur;
      logic [SPARE_PWR_W-1:0]  headroom;
      logic [COUNT_W-1:0]      count;
   } shed_cmd_type;

   typedef struct {
      logic [1:0]              action;
      logic [3:0]              index;
      logic [DEMAND_OUT_W-1:0] demand;
      logic                    last;
   } shed_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0]              req_op = '0;
   logic [3:0]              req_entry_index = '0;
   logic [ENTRY_PRIO_W-1:0] req_entry_priority = '0;
   logic [ENTRY_CUR_W-1:0]  req_entry_current = '0;
   logic [ENTRY_POW_W-1:0]  req_entry_power = '0;
   logic                    req_entry_active = 1'b0;
   logic [1:0]              req_power_level = '0;
   logic                    req_generator_present = 1'b0;
   logic [GEN_CUR_W-1:0]    req_generator_current = '0;
   logic signed [SPARE_PWR_W-1:0] req_headroom_power = '0;
   logic                    csr_wr_en = 1'b0;
   logic [COUNT_W-1:0]      csr_wr_data = '0;
   logic                    rsp_valid;
   logic [1:0]              rsp_action;
   logic [3:0]              rsp_consumer_index;
   logic [DEMAND_OUT_W-1:0] rsp_remaining_demand;
   logic                    rsp_last;

   priority_load_shedder #(.MAX_CONSUMERS(ENTRIES)) dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_op                (req_op),
      .req_entry_index       (req_entry_index),
      .req_entry_priority    (req_entry_priority),
      .req_entry_current     (req_entry_current),
      .req_entry_power       (req_entry_power),
      .req_entry_active      (req_entry_active),
      .req_power_level       (req_power_level),
      .req_generator_present (req_generator_present),
      .req_generator_current (req_generator_current),
      .req_headroom_power    (req_headroom_power),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data),
      .rsp_valid             (rsp_valid),
      .rsp_action            (rsp_action),
      .rsp_consumer_index    (rsp_consumer_index),
      .rsp_remaining_demand  (rsp_remaining_demand),
      .rsp_last              (rsp_last)
   );

   always #4 clock = ~clock;

   // consumer table as the shedder should see it
   logic [ENTRY_PRIO_W-1:0] model_prio [ENTRIES];
   logic [ENTRY_CUR_W-1:0]  model_cur [ENTRIES];
   logic [ENTRY_POW_W-1:0]  model_pow [ENTRIES];
   bit                      model_active [ENTRIES];
   logic [COUNT_W-1:0]      model_count = '0;

   shed_cmd_type  pending_cmds[$];
   shed_word_type expected_words[$];

   int fail_count = 0;
   int words_seen = 0;
   int sheds_seen = 0;
   int reacts_seen = 0;
   int items_sent = 0;
   int phases = 0;
   int cycles = 0;

   function automatic shed_cmd_type noise_cmd(logic [1:0] op);
      shed_cmd_type c;
      c.kind     = K_ITEM;
      c.op       = op;
      c.idx      = 4'($urandom);
      c.prio     = ENTRY_PRIO_W'($urandom);
      c.cur      = ENTRY_CUR_W'($urandom);
      c.pow      = ENTRY_POW_W'($urandom);
      c.act      = 1'($urandom);
      c.level    = 2'($urandom);
      c.gen      = 1'($urandom);
      c.gen_cur  = GEN_CUR_W'($urandom);
      c.headroom = SPARE_PWR_W'($urandom);
      c.count    = '0;
      return c;
   endfunction

   function automatic shed_cmd_type load_cmd(int idx, logic [ENTRY_PRIO_W-1:0] prio,
                                             logic [ENTRY_CUR_W-1:0] cur,
                                             logic [ENTRY_POW_W-1:0] pow, logic act);
      shed_cmd_type c;
      c      = noise_cmd(OP_LOAD);
      c.idx  = 4'(idx);
      c.prio = prio;
      c.cur  = cur;
      c.pow  = pow;
      c.act  = act;
      return c;
   endfunction

   function automatic shed_cmd_type level_cmd(logic [1:0] level);
      shed_cmd_type c;
      c       = noise_cmd(OP_LEVEL);
      c.level = level;
      return c;
   endfunction

   function automatic shed_cmd_type react_cmd(logic [SPARE_PWR_W-1:0] headroom);
      shed_cmd_type c;
      c          = noise_cmd(OP_REACT);
      c.headroom = headroom;
      return c;
   endfunction

   function automatic shed_cmd_type depl_cmd(logic gen, logic [GEN_CUR_W-1:0] gen_cur);
      shed_cmd_type c;
      c         = noise_cmd(OP_DEPL);
      c.gen     = gen;
      c.gen_cur = gen_cur;
      return c;
   endfunction

   function automatic void set_count(logic [COUNT_W-1:0] n);
      shed_cmd_type c;
      c       = noise_cmd(OP_LOAD);
      c.kind  = K_COUNT;
      c.count = n;
      pending_cmds.push_back(c);
   endfunction

   function automatic shed_cmd_type random_cmd();
      int r;
      int sel;
      r = $urandom_range(0, 99);
      if (r < 25)
         return load_cmd($urandom_range(0, ENTRIES - 1),
                         ENTRY_PRIO_W'(($urandom_range(0, 9) == 0) ? $urandom :
                                       $urandom_range(1, 4)),
                         ENTRY_CUR_W'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 4000) :
                                      $urandom),
                         ENTRY_POW_W'(($urandom_range(0, 4) < 3) ? $urandom_range(0, 2000) :
                                      $urandom),
                         1'($urandom));
      if (r < 50)
         return level_cmd(($urandom_range(0, 9) < 8) ? 2'($urandom_range(1, 2)) :
                          ($urandom_range(0, 1) ? LEVEL_DEPLETED : LEVEL_NORMAL));
      if (r < 85) begin
         sel = $urandom_range(0, 19);
         if (sel < 14)
            return react_cmd(SPARE_PWR_W'($urandom_range(0, 3000)));
         if (sel < 17)
            return react_cmd(SPARE_PWR_W'($urandom_range(0, 1048575)));
         return react_cmd(SPARE_PWR_W'(32'h100000 | $urandom));
      end
      sel = $urandom_range(0, 2);
      return depl_cmd($urandom_range(0, 3) != 0,
                      GEN_CUR_W'((sel == 0) ? $urandom_range(0, 20000) :
                                 (sel == 1) ? $urandom_range(0, 200000) : $urandom));
   endfunction

   function automatic void emit_word(logic [1:0] action, int index,
                                     logic [DEMAND_OUT_W-1:0] demand);
      shed_word_type w;
      w.action = action;
      w.index  = 4'(index);
      w.demand = demand;
      w.last   = 1'b0;
      expected_words.push_back(w);
   endfunction

   // apply one accepted command to the table and queue the words it must produce
   function automatic void predict_shed(shed_cmd_type c);
      int n;
      int g;
      int i;
      int base;
      bit done;
      logic [DEMAND_OUT_W-1:0] demand;
      shed_word_type w;
      n      = (int'(model_count) > ENTRIES) ? ENTRIES : int'(model_count);
      base   = expected_words.size();
      done   = 1'b0;
      demand = '0;
      case (c.op)
         OP_LOAD: begin
            model_prio[c.idx]   = c.prio;
            model_cur[c.idx]    = c.cur;
            model_pow[c.idx]    = c.pow;
            model_active[c.idx] = c.act;
            emit_word(ACT_LOAD, int'(c.idx), '0);
         end
         OP_LEVEL: begin
            if (c.level == LEVEL_WARN || c.level == LEVEL_OTHER) begin
               for (g = (c.level == LEVEL_WARN) ? int'(GROUP_LAST) : int'(GROUP_MID);
                    g >= int'(GROUP_LOWSHED) && !done; g--)
                  for (i = n - 1; i >= 0 && !done; i--)
                     if (model_active[i] && int'(model_prio[i]) == g) begin
                        model_active[i] = 1'b0;
                        emit_word(ACT_SHED, i, '0);
                        done = 1'b1;
                     end
            end
         end
         OP_REACT: begin
            // negative headroom fits nothing
            if (!c.headroom[SPARE_PWR_W-1])
               for (g = int'(GROUP_FIRST); g <= int'(GROUP_LAST) && !done; g++)
                  for (i = 0; i < n && !done; i++)
                     if (!model_active[i] && int'(model_prio[i]) == g &&
                         {1'b0, model_pow[i]} <= c.headroom) begin
                        model_active[i] = 1'b1;
                        emit_word(ACT_REACT, i, '0);
                        done = 1'b1;
                     end
         end
         OP_DEPL: begin
            for (i = 0; i < n; i++)
               if (model_active[i])
                  demand = demand + DEMAND_OUT_W'(model_cur[i]);
            if (c.gen) begin
               if (demand > c.gen_cur)
                  for (g = int'(GROUP_LAST); g >= int'(GROUP_LOWSHED) && !done; g--)
                     for (i = n - 1; i >= 0 && !done; i--)
                        if (model_active[i] && int'(model_prio[i]) == g) begin
                           demand = demand - DEMAND_OUT_W'(model_cur[i]);
                           model_active[i] = 1'b0;
                           emit_word(ACT_SHED, i, demand);
                           if (demand <= c.gen_cur)
                              done = 1'b1;
                        end
            end else begin
               // no generator: cut everything, odd priorities included
               for (i = 0; i < n; i++)
                  if (model_active[i]) begin
                     demand = demand - DEMAND_OUT_W'(model_cur[i]);
                     model_active[i] = 1'b0;
                     emit_word(ACT_SHED, i, demand);
                  end
            end
         end
      endcase
      if (expected_words.size() == base)
         emit_word(ACT_NONE, 0, demand);
      w = expected_words.pop_back();
      w.last = 1'b1;
      expected_words.push_back(w);
   endfunction

   // driver
   shed_cmd_type live_cmd;
   int idle_left = 0;
   int settle = 0;
   int gap_pct = 30;

   always @(posedge clock) begin
      shed_cmd_type c;
      logic next_start;
      logic next_wr;
      if (reset) begin
         start     <= 1'b0;
         csr_wr_en <= 1'b0;
      end else begin
         next_start = start;
         next_wr    = 1'b0;
         if (start && !busy) begin
            predict_shed(live_cmd);
            items_sent++;
            next_start = 1'b0;
            // no gaps in the closing stretch
            if (pending_cmds.size() > PHASE_ITEMS && $urandom_range(1, 100) <= gap_pct)
               idle_left = $urandom_range(1, 8);
         end
         if (start || busy || expected_words.size() != 0)
            settle = 0;
         else if (settle < SETTLE)
            settle++;
         if (!next_start) begin
            if (idle_left > 0) begin
               idle_left--;
            end else if (pending_cmds.size() != 0) begin
               if (pending_cmds[0].kind == K_ITEM) begin
                  live_cmd = pending_cmds.pop_front();
                  req_op                <= live_cmd.op;
                  req_entry_index       <= live_cmd.idx;
                  req_entry_priority    <= live_cmd.prio;
                  req_entry_current     <= live_cmd.cur;
                  req_entry_power       <= live_cmd.pow;
                  req_entry_active      <= live_cmd.act;
                  req_power_level       <= live_cmd.level;
                  req_generator_present <= live_cmd.gen;
                  req_generator_current <= live_cmd.gen_cur;
                  req_headroom_power    <= live_cmd.headroom;
                  next_start = 1'b1;
               end else if (settle >= SETTLE) begin
                  // write the count only once every word has drained
                  c = pending_cmds.pop_front();
                  model_count = c.count;
                  csr_wr_data <= c.count;
                  next_wr = 1'b1;
                  gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 60);
                  phases++;
               end
            end
         end
         start     <= next_start;
         csr_wr_en <= next_wr;
      end
   end

   // monitor
   always @(posedge clock) begin
      shed_word_type w;
      if (!reset && rsp_valid) begin
         words_seen++;
         if (expected_words.size() == 0) begin
            $error("unexpected result word: action %0d index %0d demand %0d",
                   rsp_action, rsp_consumer_index, rsp_remaining_demand);
            fail_count++;
         end else begin
            w = expected_words.pop_front();
            if (rsp_action !== w.action) begin
               $error("action: expected %0d, actual %0d", w.action, rsp_action);
               fail_count++;
            end
            if (rsp_consumer_index !== w.index) begin
               $error("consumer_index: expected %0d, actual %0d", w.index,
                      rsp_consumer_index);
               fail_count++;
            end
            if (rsp_remaining_demand !== w.demand) begin
               $error("remaining_demand: expected %0d, actual %0d", w.demand,
                      rsp_remaining_demand);
               fail_count++;
            end
            if (rsp_last !== w.last) begin
               $error("last: expected %0d, actual %0d", w.last, rsp_last);
               fail_count++;
            end
            if (w.action == ACT_SHED)
               sheds_seen++;
            if (w.action == ACT_REACT)
               reacts_seen++;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycles,
                  expected_words.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      int k;
      int p;
      int count_now;
      // empty table: nothing to scan
      pending_cmds.push_back(level_cmd(LEVEL_WARN));
      pending_cmds.push_back(react_cmd(21'h0FFFFF));
      pending_cmds.push_back(depl_cmd(1'b0, '0));
      // fill every entry before any count covers it
      for (k = 0; k < ENTRIES; k++)
         pending_cmds.push_back(load_cmd(k, FIRST_PRIO[k],
                                         ENTRY_CUR_W'((k == 0) ? 32'hFFFF : k * 3000),
                                         ENTRY_POW_W'((k == 2) ? 32'hFFFFF : k * 50),
                                         (k % 3) != 0));
      set_count(5'd31);
      pending_cmds.push_back(level_cmd(LEVEL_OTHER));
      pending_cmds.push_back(level_cmd(LEVEL_NORMAL));
      pending_cmds.push_back(level_cmd(LEVEL_DEPLETED));
      pending_cmds.push_back(react_cmd(21'h100000));
      pending_cmds.push_back(react_cmd(21'h0FFFFF));
      pending_cmds.push_back(depl_cmd(1'b1, '0));
      pending_cmds.push_back(react_cmd('0));
      pending_cmds.push_back(depl_cmd(1'b1, 20'hFFFFF));
      pending_cmds.push_back(depl_cmd(1'b0, '0));

      for (p = 0; p < PHASES; p++) begin
         case (p)
            0: count_now = ENTRIES;
            1: count_now = 1;
            2: count_now = 31;
            3: count_now = 0;
            default: count_now = $urandom_range(2, 20);
         endcase
         set_count(COUNT_W'(count_now));
         for (k = 0; k < PHASE_ITEMS; k++)
            pending_cmds.push_back(random_cmd());
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_cmds.size() != 0 || start || expected_words.size() != 0)
         @(posedge clock);
      repeat (TAIL) @(posedge clock);

      $display("Ran %0d commands under %0d consumer-count settings, %0d result words checked.",
               items_sent, phases, words_seen);
      $display("Seen %0d consumers shed and %0d reactivated.", sheds_seen, reacts_seen);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
